@@ src/wlfd_pkg.sv @@
// ---------------------------------------------------------------------------
// wlfd_pkg: shared types and codes for the water level fill/drain controller
// Mode codes, level codes, register map, config and drive bundles.
// ---------------------------------------------------------------------------
package wlfd_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned LVL_W   = 3;
  localparam int unsigned FRAME_W = 2;

  // control modes
  localparam logic [MODE_W-1:0] MODE_RESET       = 4'd0;
  localparam logic [MODE_W-1:0] MODE_IDLE        = 4'd1;
  localparam logic [MODE_W-1:0] MODE_FILL        = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DRAIN       = 4'd3;
  localparam logic [MODE_W-1:0] MODE_FILL_TIMER  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_DRAIN_TIMER = 4'd5;
  localparam logic [MODE_W-1:0] MODE_WAIT_HIGH   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_WAIT_LOW    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_MANUAL      = 4'd8;
  localparam logic [MODE_W-1:0] MODE_ERROR       = 4'd9;
  localparam logic [MODE_W-1:0] MODE_NONE        = 4'd15;

  // sensor levels
  localparam logic [LVL_W-1:0] LVL_LOW   = 3'd0;
  localparam logic [LVL_W-1:0] LVL_MID   = 3'd1;
  localparam logic [LVL_W-1:0] LVL_HIGH  = 3'd2;
  localparam logic [LVL_W-1:0] LVL_ERROR = 3'd3;

  // animation frames
  localparam logic [FRAME_W-1:0] FRAME_HIGH = 2'd0;
  localparam logic [FRAME_W-1:0] FRAME_MID  = 2'd1;
  localparam logic [FRAME_W-1:0] FRAME_LOW  = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_FILL_TIME   = 3'd0;
  localparam logic [2:0] REG_DRAIN_TIME  = 3'd1;
  localparam logic [2:0] REG_WAIT_TIME   = 3'd2;
  localparam logic [2:0] REG_ANIM_PERIOD = 3'd3;
  localparam logic [2:0] REG_BLINK_PERIOD = 3'd4;

  localparam logic [DATA_W-1:0] FILL_TIME_RST    = 32'd5000;
  localparam logic [DATA_W-1:0] DRAIN_TIME_RST   = 32'd5000;
  localparam logic [DATA_W-1:0] WAIT_TIME_RST    = 32'd60000;
  localparam logic [DATA_W-1:0] ANIM_PERIOD_RST  = 32'd200;
  localparam logic [DATA_W-1:0] BLINK_PERIOD_RST = 32'd500;

  typedef struct packed {
    logic [DATA_W-1:0] fill_time_ms;
    logic [DATA_W-1:0] drain_time_ms;
    logic [DATA_W-1:0] wait_time_ms;
    logic [DATA_W-1:0] animation_period_ms;
    logic [DATA_W-1:0] blink_period_ms;
  } cfg_t;

  typedef struct packed {
    logic              fill_valve;
    logic              drain_valve;
    logic              high_led;
    logic              mid_led;
    logic              low_led;
    logic [MODE_W-1:0] mode_code;
  } drives_t;

endpackage

@@ src/wlfd_in_if.sv @@
// ---------------------------------------------------------------------------
// wlfd_in_if: input channel of one control-loop pass
// Valid/ready handshake carrying time stamp, level code and switch.
// ---------------------------------------------------------------------------
interface wlfd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [2:0]  sensor_level;
  logic        drain_switch;

  modport source (output valid, now_ms, sensor_level, drain_switch, input ready);
  modport sink   (input valid, now_ms, sensor_level, drain_switch, output ready);
endinterface

@@ src/wlfd_out_if.sv @@
// ---------------------------------------------------------------------------
// wlfd_out_if: result channel of the controller
// Valid/ready handshake carrying valve drives, lamp drives and mode.
// ---------------------------------------------------------------------------
interface wlfd_out_if;
  logic       valid;
  logic       ready;
  logic       fill_valve;
  logic       drain_valve;
  logic       high_led;
  logic       mid_led;
  logic       low_led;
  logic [3:0] mode_code;

  modport source (output valid, fill_valve, drain_valve, high_led, mid_led, low_led,
                  mode_code, input ready);
  modport sink   (input valid, fill_valve, drain_valve, high_led, mid_led, low_led,
                  mode_code, output ready);
endinterface

@@ src/water_level_fill_drain_controller_top.sv @@
// ---------------------------------------------------------------------------
// water_level_fill_drain_controller_top: water level fill/drain controller
// One control-loop pass per input word; one drive word per pass.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------
//  in_ch    | in  | valid/ready        | now_ms, sensor_level, drain_switch
//  out_ch   | out | valid/ready        | valves, lamps, mode_code
//  apb      | in  | psel/penable/pready| paddr[4:0], pwdata/prdata 32 bits
//
//  An accepted word is held in the input register, then passes through mode
//  logic and decode into the result register. Throughput is one word per
//  cycle while out_ch.ready is high; the mode and display registers update
//  when a word moves from the input register into the result register.
//  A stalled result holds both registers; in_ch.ready drops only when both
//  are full and out_ch.ready is low. Reset is synchronous, active high.
// ---------------------------------------------------------------------------
module water_level_fill_drain_controller_top
  import wlfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  wlfd_in_if.sink            in_ch,
  wlfd_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t              cfg;
  logic              in_valid;
  logic [DATA_W-1:0] now_ms;
  logic [LVL_W-1:0]  sensor_level;
  logic              drain_switch;
  logic              out_valid;
  drives_t           result;
  drives_t           drives;
  logic [MODE_W-1:0] mode_next;
  logic              out_free;
  logic              fire;

  assign out_free    = !out_valid || out_ch.ready;
  assign fire        = in_valid && out_free;
  assign in_ch.ready = !in_valid || out_free;

  wlfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      now_ms       <= in_ch.now_ms;
      sensor_level <= in_ch.sensor_level;
      drain_switch <= in_ch.drain_switch;
    end
  end

  wlfd_mode_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .now_ms       (now_ms),
    .sensor_level (sensor_level),
    .drain_switch (drain_switch),
    .cfg          (cfg),
    .mode_next    (mode_next)
  );

  wlfd_display u_disp (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .now_ms    (now_ms),
    .mode_next (mode_next),
    .cfg       (cfg),
    .drives    (drives)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= drives;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.fill_valve  = result.fill_valve;
  assign out_ch.drain_valve = result.drain_valve;
  assign out_ch.high_led    = result.high_led;
  assign out_ch.mid_led     = result.mid_led;
  assign out_ch.low_led     = result.low_led;
  assign out_ch.mode_code   = result.mode_code;

`ifndef SYNTHESIS
  a_fire_to_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed word did not reach result register");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid && $stable(now_ms))
    else $error("held input word lost while result stalled");
`endif

endmodule

@@ src/wlfd_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// wlfd_cfg_regs: APB register file
// Five 32-bit timing registers at byte addresses 0, 4, 8, 12, 16.
// ---------------------------------------------------------------------------
module wlfd_cfg_regs
  import wlfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fill_time_ms        <= FILL_TIME_RST;
      cfg.drain_time_ms       <= DRAIN_TIME_RST;
      cfg.wait_time_ms        <= WAIT_TIME_RST;
      cfg.animation_period_ms <= ANIM_PERIOD_RST;
      cfg.blink_period_ms     <= BLINK_PERIOD_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FILL_TIME:    cfg.fill_time_ms        <= pwdata;
        REG_DRAIN_TIME:   cfg.drain_time_ms       <= pwdata;
        REG_WAIT_TIME:    cfg.wait_time_ms        <= pwdata;
        REG_ANIM_PERIOD:  cfg.animation_period_ms <= pwdata;
        REG_BLINK_PERIOD: cfg.blink_period_ms     <= pwdata;
        default: ;  // drop writes past the map
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FILL_TIME:    prdata = cfg.fill_time_ms;
      REG_DRAIN_TIME:   prdata = cfg.drain_time_ms;
      REG_WAIT_TIME:    prdata = cfg.wait_time_ms;
      REG_ANIM_PERIOD:  prdata = cfg.animation_period_ms;
      REG_BLINK_PERIOD: prdata = cfg.blink_period_ms;
      default:          prdata = '0;
    endcase
  end

endmodule

@@ src/wlfd_mode_fsm.sv @@
// ---------------------------------------------------------------------------
// wlfd_mode_fsm: control mode machine
// Overrides, level transitions and entry-relative timers; holds mode and
// the entry time stamp.
// ---------------------------------------------------------------------------
module wlfd_mode_fsm
  import wlfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [DATA_W-1:0] now_ms,
  input  logic [LVL_W-1:0]  sensor_level,
  input  logic              drain_switch,
  input  cfg_t              cfg,
  output logic [MODE_W-1:0] mode_next
);

  logic [MODE_W-1:0] control_mode;
  logic [DATA_W-1:0] entry_time;
  logic [DATA_W-1:0] elapsed;
  logic              fill_done;
  logic              drain_done;
  logic              wait_done;

  // elapsed wraps modulo 2^32
  assign elapsed    = now_ms - entry_time;
  assign fill_done  = elapsed >= cfg.fill_time_ms;
  assign drain_done = elapsed >= cfg.drain_time_ms;
  assign wait_done  = elapsed >= cfg.wait_time_ms;

  always_comb begin
    mode_next = control_mode;
    if (drain_switch) begin
      mode_next = MODE_MANUAL;
    end else if (sensor_level == LVL_ERROR) begin
      mode_next = MODE_ERROR;
    end else if (sensor_level > LVL_ERROR) begin
      mode_next = MODE_RESET;
    end else begin
      case (control_mode)
        MODE_RESET, MODE_IDLE: begin
          if (sensor_level == LVL_HIGH)     mode_next = MODE_DRAIN;
          else if (sensor_level == LVL_LOW) mode_next = MODE_FILL;
          else                              mode_next = MODE_IDLE;
        end
        MODE_FILL: begin
          if (sensor_level == LVL_HIGH)     mode_next = MODE_WAIT_HIGH;
          else if (sensor_level == LVL_MID) mode_next = MODE_FILL_TIMER;
        end
        MODE_DRAIN: begin
          if (sensor_level == LVL_LOW)      mode_next = MODE_WAIT_LOW;
          else if (sensor_level == LVL_MID) mode_next = MODE_DRAIN_TIMER;
        end
        MODE_FILL_TIMER: begin
          if (sensor_level == LVL_HIGH)     mode_next = MODE_WAIT_HIGH;
          else if (sensor_level == LVL_LOW) mode_next = MODE_FILL;
          else if (fill_done)               mode_next = MODE_IDLE;
        end
        MODE_DRAIN_TIMER: begin
          if (sensor_level == LVL_LOW)       mode_next = MODE_WAIT_LOW;
          else if (sensor_level == LVL_HIGH) mode_next = MODE_DRAIN;
          else if (drain_done)               mode_next = MODE_IDLE;
        end
        MODE_WAIT_HIGH, MODE_WAIT_LOW: begin
          if (wait_done) mode_next = MODE_IDLE;
        end
        default: mode_next = MODE_RESET;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_mode <= MODE_RESET;
      entry_time   <= '0;
    end else if (fire && (mode_next != control_mode)) begin
      control_mode <= mode_next;
      entry_time   <= now_ms;
    end
  end

`ifndef SYNTHESIS
  a_switch_manual: assert property (@(posedge clk) disable iff (rst)
    fire && drain_switch |=> control_mode == MODE_MANUAL)
    else $error("manual switch did not force manual mode");

  a_error_level: assert property (@(posedge clk) disable iff (rst)
    fire && !drain_switch && sensor_level == LVL_ERROR |=> control_mode == MODE_ERROR)
    else $error("error level did not force error mode");

  a_entry_stamp: assert property (@(posedge clk) disable iff (rst)
    fire && (mode_next != control_mode) |=> entry_time == $past(now_ms))
    else $error("entry time not taken on mode change");
`endif

endmodule

@@ src/wlfd_display.sv @@
// ---------------------------------------------------------------------------
// wlfd_display: blink/animation timing and drive decode
// Restarts blink and animation on a shown-mode change, steps them on their
// periods, and decodes valve and lamp drives from the new mode.
// ---------------------------------------------------------------------------
module wlfd_display
  import wlfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [DATA_W-1:0] now_ms,
  input  logic [MODE_W-1:0] mode_next,
  input  cfg_t              cfg,
  output drives_t           drives
);

  logic [MODE_W-1:0]  shown_mode;
  logic [DATA_W-1:0]  animation_mark;
  logic [DATA_W-1:0]  blink_mark;
  logic               blink_on;
  logic [FRAME_W-1:0] animation_frame;

  logic [MODE_W-1:0]  shown_mode_next;
  logic [DATA_W-1:0]  animation_mark_next;
  logic [DATA_W-1:0]  blink_mark_next;
  logic               blink_on_next;
  logic [FRAME_W-1:0] animation_frame_next;

  logic               mode_changed;
  logic               anim_hit;
  logic               blink_hit;

  assign mode_changed = mode_next != shown_mode;
  assign anim_hit     = (now_ms - animation_mark) >= cfg.animation_period_ms;
  assign blink_hit    = (now_ms - blink_mark) >= cfg.blink_period_ms;

  always_comb begin
    shown_mode_next      = mode_next;
    animation_mark_next  = animation_mark;
    blink_mark_next      = blink_mark;
    blink_on_next        = blink_on;
    animation_frame_next = animation_frame;
    if (mode_changed) begin
      animation_mark_next  = now_ms;
      blink_mark_next      = now_ms;
      animation_frame_next = FRAME_HIGH;
      blink_on_next        = 1'b1;
    end else begin
      if (anim_hit) begin
        animation_mark_next  = now_ms;
        animation_frame_next = (animation_frame >= FRAME_LOW) ? FRAME_HIGH
                                                              : animation_frame + 2'd1;
      end
      if (blink_hit) begin
        blink_mark_next = now_ms;
        blink_on_next   = !blink_on;
      end
    end
  end

  always_comb begin
    drives           = '0;
    drives.mode_code = mode_next;
    case (mode_next)
      MODE_RESET: drives.mid_led = blink_on_next;
      MODE_IDLE:  drives.mid_led = 1'b1;
      MODE_FILL: begin
        drives.fill_valve = 1'b1;
        drives.low_led    = 1'b1;
      end
      MODE_DRAIN: begin
        drives.drain_valve = 1'b1;
        drives.high_led    = 1'b1;
      end
      MODE_FILL_TIMER: begin
        drives.fill_valve = 1'b1;
        drives.low_led    = 1'b1;
        drives.mid_led    = blink_on_next;
      end
      MODE_DRAIN_TIMER: begin
        drives.drain_valve = 1'b1;
        drives.high_led    = 1'b1;
        drives.mid_led     = blink_on_next;
      end
      MODE_WAIT_HIGH: drives.high_led = blink_on_next;
      MODE_WAIT_LOW:  drives.low_led  = blink_on_next;
      MODE_MANUAL: begin
        drives.drain_valve = 1'b1;
        drives.high_led    = animation_frame_next == FRAME_HIGH;
        drives.mid_led     = animation_frame_next == FRAME_MID;
        drives.low_led     = animation_frame_next == FRAME_LOW;
      end
      MODE_ERROR: begin
        drives.high_led = blink_on_next;
        drives.mid_led  = blink_on_next;
        drives.low_led  = blink_on_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_mode      <= MODE_NONE;
      animation_mark  <= '0;
      blink_mark      <= '0;
      blink_on        <= 1'b0;
      animation_frame <= FRAME_HIGH;
    end else if (fire) begin
      shown_mode      <= shown_mode_next;
      animation_mark  <= animation_mark_next;
      blink_mark      <= blink_mark_next;
      blink_on        <= blink_on_next;
      animation_frame <= animation_frame_next;
    end
  end

`ifndef SYNTHESIS
  a_restart: assert property (@(posedge clk) disable iff (rst)
    fire && mode_changed |=> blink_on && animation_frame == FRAME_HIGH)
    else $error("blink/animation not restarted on mode change");

  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    animation_frame != 2'd3)
    else $error("animation frame out of sequence");
`endif

endmodule
